// ===== design/pwbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Pixel write and blend engine package
// Shared payload types, status and request codes, and configuration indexes.
// ----------------------------------------------------------------------------
package pwbe_pkg;

    localparam int ADDR_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_CLIPPED    = 3'd1;
    localparam logic [2:0] ST_BEYOND     = 3'd2;
    localparam logic [2:0] ST_DEPTH      = 3'd3;
    localparam logic [2:0] ST_ALPHA_ZERO = 3'd4;

    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_BLEND = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VIS_W      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIS_H      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIX_BITS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_USED = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [31:0] color;
        logic [8:0]  alpha;
    } t_request;

    typedef struct packed {
        logic [2:0]  status;
        logic [20:0] byte_address;
        logic [31:0] pixel_value;
    } t_result;

    typedef struct packed {
        logic [2:0]        status;
        logic [1:0]        op;
        logic              is16;
        logic              blend;
        logic [7:0]        alpha8;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       color;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== design/pwbe_front.sv =====
// ----------------------------------------------------------------------------
// Pixel write and blend engine front end
// Holds the configuration registers, accepts requests and classifies them
// into status, byte address and operation for the back end.
// ----------------------------------------------------------------------------
module pwbe_front #(
    parameter int FRAME_BYTES = 2097152
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_hold,
    input  logic                                i_start,
    input  pwbe_pkg::t_request                  i_req,
    output logic                                o_busy,
    input  logic                                i_cfg_valid,
    input  logic [pwbe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pwbe_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  pwbe_pkg::t_q_status                 i_q,
    output logic                                o_push,
    output pwbe_pkg::t_entry                    o_entry
);
    import pwbe_pkg::*;

    localparam int LIMIT_W = ADDR_W + 1;
    localparam int SUM_W   = 30;

    logic [12:0] r_vis_w;
    logic [12:0] r_vis_h;
    logic [11:0] r_pan_x;
    logic [11:0] r_pan_y;
    logic [5:0]  r_pix_bits;
    logic [14:0] r_pitch;
    logic [21:0] r_used;

    logic        r_f1_valid;
    t_request    r_f1;
    logic [27:0] r_f1_prod;

    logic               w_accept;
    logic [12:0]        w_y;
    logic [27:0]        w_prod;
    logic [1:0]         w_req;
    logic               w_is16;
    logic               w_is32;
    logic [12:0]        w_x;
    logic [14:0]        w_xoff;
    logic [SUM_W-1:0]   w_addr;
    logic [SUM_W-1:0]   w_end;
    logic [LIMIT_W-1:0] w_limit;
    logic [2:0]         w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis_w    <= 13'd640;
            r_vis_h    <= 13'd480;
            r_pan_x    <= 12'd0;
            r_pan_y    <= 12'd0;
            r_pix_bits <= 6'd32;
            r_pitch    <= 15'd2560;
            r_used     <= 22'd1228800;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VIS_W:      r_vis_w    <= i_cfg_data[12:0];
                CFG_VIS_H:      r_vis_h    <= i_cfg_data[12:0];
                CFG_PAN_X:      r_pan_x    <= i_cfg_data[11:0];
                CFG_PAN_Y:      r_pan_y    <= i_cfg_data[11:0];
                CFG_PIX_BITS:   r_pix_bits <= i_cfg_data[5:0];
                CFG_PITCH:      r_pitch    <= i_cfg_data[14:0];
                CFG_FRAME_USED: r_used     <= i_cfg_data[21:0];
                default: begin
                end
            endcase
        end
    end

    assign o_busy   = i_hold || (r_f1_valid && i_q.full);
    assign w_accept = i_start && !o_busy;
    assign o_push   = r_f1_valid && !i_q.full;

    assign w_y    = {1'b0, i_req.pos_y} + {1'b0, r_pan_y};
    assign w_prod = 28'(w_y) * 28'(r_pitch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= w_accept || (r_f1_valid && i_q.full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f1      <= i_req;
            r_f1_prod <= w_prod;
        end
    end

    assign w_req  = (r_f1.req_type == REQ_SET || r_f1.req_type == REQ_BLEND)
                    ? r_f1.req_type : REQ_READ;
    assign w_is16 = (r_pix_bits == 6'd16);
    assign w_is32 = (r_pix_bits == 6'd32);
    assign w_x    = {1'b0, r_f1.pos_x} + {1'b0, r_pan_x};
    assign w_xoff = w_is32 ? {w_x, 2'b00} : {1'b0, w_x, 1'b0};
    assign w_addr = SUM_W'(r_f1_prod) + SUM_W'(w_xoff);
    assign w_end  = w_addr + (w_is16 ? SUM_W'(2) : SUM_W'(4));
    assign w_limit = (LIMIT_W'(r_used) < LIMIT_W'(FRAME_BYTES))
                     ? LIMIT_W'(r_used) : LIMIT_W'(FRAME_BYTES);

    always_comb begin
        if ({1'b0, r_f1.pos_x} >= r_vis_w || {1'b0, r_f1.pos_y} >= r_vis_h) begin
            w_status = ST_CLIPPED;
        end else if (w_req == REQ_BLEND && r_f1.alpha == 9'd0) begin
            w_status = ST_ALPHA_ZERO;
        end else if (!w_is16 && !w_is32) begin
            w_status = ST_DEPTH;
        end else if (w_end > SUM_W'(w_limit)) begin
            w_status = ST_BEYOND;
        end else begin
            w_status = ST_DONE;
        end
    end

    always_comb begin
        o_entry.status = w_status;
        o_entry.op     = w_req;
        o_entry.is16   = w_is16;
        o_entry.blend  = (w_req == REQ_BLEND) && (r_f1.alpha < 9'd256);
        o_entry.alpha8 = r_f1.alpha[7:0];
        o_entry.addr   = w_addr[ADDR_W-1:0];
        o_entry.color  = r_f1.color;
    end

endmodule

// ===== design/pwbe_queue.sv =====
// ----------------------------------------------------------------------------
// Pixel write and blend engine queue
// Two-entry queue of classified requests between front end and back end.
// ----------------------------------------------------------------------------
module pwbe_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pwbe_pkg::t_entry    i_entry,
    input  logic                i_pop,
    output pwbe_pkg::t_entry    o_head,
    output pwbe_pkg::t_q_status o_q
);
    import pwbe_pkg::*;

    t_entry     r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_entry;
        end
    end

    assign o_head  = r_slot[r_rd];
    assign o_q.full  = (r_cnt == 2'd2);
    assign o_q.empty = (r_cnt == 2'd0);

endmodule

// ===== design/pwbe_back.sv =====
// ----------------------------------------------------------------------------
// Pixel write and blend engine back end
// Owns the frame store as two word banks, clears it after reset, and carries
// out reads, sets and blends of queued requests.
// ----------------------------------------------------------------------------
module pwbe_back #(
    parameter int FRAME_BYTES = 2097152
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pwbe_pkg::t_q_status i_q,
    input  pwbe_pkg::t_entry    i_head,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_res_valid,
    output pwbe_pkg::t_result   o_res
);
    import pwbe_pkg::*;

    localparam int WORDS = (FRAME_BYTES + 3) / 4;
    localparam int ROWS  = (WORDS + 1) / 2;
    localparam int ROW_W = $clog2(ROWS);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_DATA  = 4'b0100,
        S_MIX   = 4'b1000
    } t_back_state;

    function automatic logic [ROW_W-1:0] even_row(input logic [ADDR_W-1:0] a);
        even_row = a[ROW_W+2:3] + ROW_W'(a[2]);
    endfunction

    function automatic logic [ROW_W-1:0] odd_row(input logic [ADDR_W-1:0] a);
        odd_row = a[ROW_W+2:3];
    endfunction

    function automatic logic [15:0] pack565(input logic [31:0] c);
        pack565 = {c[23:19], c[15:10], c[7:3]};
    endfunction

    function automatic logic [31:0] unpack565(input logic [15:0] p);
        unpack565 = {8'h00, p[15:11], 3'b000, p[10:5], 2'b00, p[4:0], 3'b000};
    endfunction

    logic [31:0] r_bank0 [ROWS];
    logic [31:0] r_bank1 [ROWS];
    logic [31:0] r_rd0;
    logic [31:0] r_rd1;

    t_back_state        r_state;
    t_back_state        n_state;
    logic [ROW_W-1:0]   r_clr;
    t_entry             r_cur;
    logic signed [17:0] r_prod [3];
    logic [7:0]         r_bg [3];
    logic               r_out_valid;
    t_result            r_out;

    logic [1:0]         w_off;
    logic               w_odd;
    logic [63:0]        w_win;
    logic [63:0]        w_shift;
    logic [31:0]        w_raw;
    logic [31:0]        w_bgw;
    logic signed [8:0]  w_diff [3];
    logic signed [17:0] w_sum [3];
    logic [31:0]        w_c;
    logic [31:0]        w_val;
    logic [63:0]        w_wwin;
    logic [7:0]         w_wbe;
    logic               w_store;
    logic               w_emit;
    logic               w_we;
    logic [ROW_W-1:0]   w_row0;
    logic [ROW_W-1:0]   w_row1;
    logic [31:0]        w_wd0;
    logic [31:0]        w_wd1;
    logic [3:0]         w_be0;
    logic [3:0]         w_be1;

    assign o_clearing = (r_state == S_CLEAR);

    assign w_off   = r_cur.addr[1:0];
    assign w_odd   = r_cur.addr[2];
    assign w_win   = w_odd ? {r_rd0, r_rd1} : {r_rd1, r_rd0};
    assign w_shift = w_win >> {w_off, 3'b000};
    assign w_raw   = r_cur.is16 ? {16'h0000, w_shift[15:0]} : w_shift[31:0];
    assign w_bgw   = r_cur.is16 ? unpack565(w_raw[15:0]) : w_raw;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_diff[i] = $signed({1'b0, r_cur.color[8*i +: 8]}) - $signed({1'b0, w_bgw[8*i +: 8]});
            w_sum[i]  = $signed({2'b00, r_bg[i], 8'h00}) + r_prod[i];
        end
    end

    assign w_c   = (r_state == S_MIX)
                   ? {8'h00, w_sum[2][15:8], w_sum[1][15:8], w_sum[0][15:8]}
                   : r_cur.color;
    assign w_val = r_cur.is16 ? {16'h0000, pack565(w_c)} : w_c;
    assign w_wwin = {32'h0, w_val} << {w_off, 3'b000};
    assign w_wbe  = {4'h0, (r_cur.is16 ? 4'b0011 : 4'b1111)} << w_off;

    assign w_store = ((r_state == S_DATA) && r_cur.op != REQ_READ && !r_cur.blend)
                     || (r_state == S_MIX);

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == ROW_W'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q.empty) begin
                    o_pop = 1'b1;
                    if (i_head.status == ST_DONE) begin
                        n_state = S_DATA;
                    end
                end
            end
            S_DATA: begin
                n_state = r_cur.blend ? S_MIX : S_IDLE;
            end
            S_MIX: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_emit = ((r_state == S_IDLE) && o_pop && i_head.status != ST_DONE)
                    || ((r_state == S_DATA) && !r_cur.blend)
                    || (r_state == S_MIX);

    always_comb begin
        if (o_clearing) begin
            w_we   = 1'b1;
            w_row0 = r_clr;
            w_row1 = r_clr;
            w_wd0  = 32'h0;
            w_wd1  = 32'h0;
            w_be0  = 4'hF;
            w_be1  = 4'hF;
        end else begin
            w_we   = w_store;
            w_row0 = even_row(r_cur.addr);
            w_row1 = odd_row(r_cur.addr);
            w_wd0  = w_odd ? w_wwin[63:32] : w_wwin[31:0];
            w_wd1  = w_odd ? w_wwin[31:0] : w_wwin[63:32];
            w_be0  = w_odd ? w_wbe[7:4] : w_wbe[3:0];
            w_be1  = w_odd ? w_wbe[3:0] : w_wbe[7:4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            for (int b = 0; b < 4; b++) begin
                if (w_be0[b]) begin
                    r_bank0[w_row0][8*b +: 8] <= w_wd0[8*b +: 8];
                end
            end
        end
        r_rd0 <= r_bank0[even_row(i_head.addr)];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            for (int b = 0; b < 4; b++) begin
                if (w_be1[b]) begin
                    r_bank1[w_row1][8*b +: 8] <= w_wd1[8*b +: 8];
                end
            end
        end
        r_rd1 <= r_bank1[odd_row(i_head.addr)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= w_emit;
            if (o_clearing) begin
                r_clr <= r_clr + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        if (r_state == S_DATA) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= w_diff[i] * $signed({1'b0, r_cur.alpha8});
                r_bg[i]   <= w_bgw[8*i +: 8];
            end
        end
        if (r_state == S_IDLE) begin
            r_out.status       <= i_head.status;
            r_out.byte_address <= 21'd0;
            r_out.pixel_value  <= 32'd0;
        end else begin
            r_out.status       <= ST_DONE;
            r_out.byte_address <= r_cur.addr[20:0];
            r_out.pixel_value  <= (r_cur.op == REQ_READ) ? w_raw : w_val;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== design/pixel_write_blend_engine_top.sv =====
// An accepted request is registered in the front end, pushed into the queue and popped by
// the back end, which registers its result. The back end's single frame store port pair
// handles a rejected request in the idle state alone, a read or set in the idle and data
// states, and a blend with alpha below 256 in the idle, data and mix states; busy rises
// when the two-entry queue and the front register are full. Results strobe for one cycle
// only. After reset the frame store is cleared to zero, one row of two words per cycle, with busy high.
// ----------------------------------------------------------------------------
// Pixel write and blend engine top level
// Set, blend and read of single pixels in a byte frame store at 16 or 32 bpp.
// ----------------------------------------------------------------------------
module pixel_write_blend_engine_top #(
    parameter int FRAME_BYTES = 2097152
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  pwbe_pkg::t_request               i_req,
    output logic                             o_res_valid,
    output pwbe_pkg::t_result                o_res,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pwbe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pwbe_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pwbe_pkg::*;

    logic      w_clearing;
    logic      w_push;
    logic      w_pop;
    t_entry    w_entry;
    t_entry    w_head;
    t_q_status w_q;

    assign o_cfg_ready = 1'b1;

    pwbe_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (w_clearing),
        .i_start     (start),
        .i_req       (i_req),
        .o_busy      (busy),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q         (w_q),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    pwbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_q     (w_q)
    );

    pwbe_back #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (w_q),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

`ifndef NO_ASSERTIONS
    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_res_valid)
        else $error("result beat during frame store clearing");

    a_busy_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> busy)
        else $error("requests accepted during frame store clearing");

    a_reject_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != ST_DONE)
        |-> (o_res.byte_address == 21'd0 && o_res.pixel_value == 32'd0))
        else $error("rejected request carries address or value");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q.full)
        else $error("queue push while full");
`endif

endmodule

// ===== dv/pixel_write_blend_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// Pixel write and blend engine testbench
// Drives set, blend and read requests through the start/busy port and checks every
// result beat against a local model of the frame store and registers or, for marked
// rows, the directed table, which covers extremes and corner cases; then randomized
// phases under varied frame layouts and sender idling exercise overlapping accesses.
// ----------------------------------------------------------------------------
module pixel_write_blend_engine_top_tb;

    import pwbe_pkg::*;

    localparam int          FRAME_BYTES = 2097152;
    localparam int          STALL_LIMIT = 800000;
    localparam int          TAIL_CYCLES = 16;
    localparam int unsigned ALPHA_ONE   = 256;
    localparam int unsigned BPP16       = 16;
    localparam int unsigned BPP32       = 32;
    localparam int unsigned IDLE_NONE   = 0;
    localparam int unsigned IDLE_LIGHT  = 15;
    localparam int unsigned IDLE_HEAVY  = 63;
    localparam logic [1:0]  REQ_SPARE   = 2'b11;

    typedef struct {
        t_request rq;
        bit       typed;
        t_result  exp;
    } t_pixel_job;

    typedef struct {
        int unsigned bits;
        int unsigned used;
        logic [1:0]  op;
        int unsigned x;
        int unsigned y;
        logic [31:0] color;
        int unsigned alpha;
        bit          typed;
        logic [2:0]  status;
        int unsigned addr;
        logic [31:0] value;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 25;

    t_directed_row directed_plan [0:DIRECTED_ROWS-1] = '{
        '{32, 1228800, REQ_READ,  0,    0,    32'h0000_0000, 0,   1, ST_DONE, 0, 32'h0000_0000},
        '{32, 1228800, REQ_SET,   0,    0,    32'hFFFF_FFFF, 0,   1, ST_DONE, 0, 32'hFFFF_FFFF},
        '{32, 1228800, REQ_READ,  0,    0,    32'h0000_0000, 0,   1, ST_DONE, 0, 32'hFFFF_FFFF},
        '{32, 1228800, REQ_BLEND, 0,    0,    32'h0000_0000, 0,   1, ST_ALPHA_ZERO, 0, 32'h0},
        '{32, 1228800, REQ_BLEND, 0,    0,    32'h0000_0000, 128, 0, ST_DONE, 0, 32'h0},
        '{32, 1228800, REQ_BLEND, 0,    0,    32'h0012_3456, 256, 1, ST_DONE, 0, 32'h0012_3456},
        '{32, 1228800, REQ_BLEND, 1,    0,    32'hAB00_0000, 511, 1, ST_DONE, 4, 32'hAB00_0000},
        '{32, 1228800, REQ_SPARE, 1,    0,    32'h0000_0000, 0,   0, ST_DONE, 0, 32'h0},
        '{32, 1228800, REQ_SET,   639,  479,  32'h89AB_CDEF, 1,   1, ST_DONE, 1228796,
          32'h89AB_CDEF},
        '{32, 1228800, REQ_SET,   640,  0,    32'h1234_5678, 256, 1, ST_CLIPPED, 0, 32'h0},
        '{32, 1228800, REQ_READ,  0,    480,  32'h0000_0000, 0,   1, ST_CLIPPED, 0, 32'h0},
        '{32, 1228800, REQ_SET,   4095, 4095, 32'hFFFF_FFFF, 511, 1, ST_CLIPPED, 0, 32'h0},
        '{32, 1228800, REQ_BLEND, 4095, 0,    32'hFFFF_FFFF, 0,   1, ST_CLIPPED, 0, 32'h0},
        '{32, 1228800, REQ_BLEND, 1,    1,    32'h00FF_00FF, 1,   0, ST_DONE, 0, 32'h0},
        '{32, 1228800, REQ_BLEND, 1,    1,    32'h00FF_FFFF, 255, 0, ST_DONE, 0, 32'h0},
        '{32, 1228796, REQ_SET,   639,  479,  32'h5555_AAAA, 256, 1, ST_BEYOND, 0, 32'h0},
        '{32, 1228796, REQ_READ,  638,  479,  32'h0000_0000, 0,   0, ST_DONE, 0, 32'h0},
        '{16, 1228800, REQ_SET,   2,    0,    32'h00FF_FFFF, 256, 0, ST_DONE, 0, 32'h0},
        '{16, 1228800, REQ_BLEND, 2,    0,    32'h0000_0000, 128, 0, ST_DONE, 0, 32'h0},
        '{16, 1228800, REQ_READ,  3,    0,    32'h0000_0000, 0,   0, ST_DONE, 0, 32'h0},
        '{24, 1228800, REQ_SET,   0,    0,    32'h00C0_FFEE, 256, 1, ST_DEPTH, 0, 32'h0},
        '{24, 1228800, REQ_BLEND, 0,    0,    32'h00C0_FFEE, 0,   1, ST_ALPHA_ZERO, 0, 32'h0},
        '{0,  1228800, REQ_READ,  0,    0,    32'h0000_0000, 0,   1, ST_DEPTH, 0, 32'h0},
        '{63, 1228800, REQ_SET,   5,    5,    32'h0000_0001, 256, 1, ST_DEPTH, 0, 32'h0},
        '{32, 0,       REQ_READ,  0,    0,    32'h0000_0000, 0,   1, ST_BEYOND, 0, 32'h0}
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_request              i_req       = '0;
    logic                  o_res_valid;
    t_result               o_res;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    bit [7:0]    frame_image [0:FRAME_BYTES-1];
    logic [12:0] vis_w      = 13'd640;
    logic [12:0] vis_h      = 13'd480;
    logic [11:0] pan_x      = 12'd0;
    logic [11:0] pan_y      = 12'd0;
    logic [5:0]  pix_bits   = 6'd32;
    logic [14:0] line_pitch = 15'd2560;
    logic [21:0] frame_used = 22'd1228800;

    t_pixel_job  job_fifo [$];
    t_pixel_job  cur_job;
    t_result     pending_results [$];
    bit          took;
    int unsigned idle_pct;
    int          stall_cycles;
    int          mismatches;

    pixel_write_blend_engine_top #(
        .FRAME_BYTES(FRAME_BYTES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] mix_channel(logic [7:0] fg, logic [7:0] bg,
                                               logic [8:0] wgt);
        int unsigned sum;
        sum = fg * wgt + bg * (ALPHA_ONE - wgt);
        return sum[15:8];
    endfunction

    function automatic t_result predict_pixel(t_request rq);
        logic [1:0]      op;
        logic [8:0]      wgt;
        int unsigned     nb;
        longint unsigned addr;
        longint unsigned lim;
        logic [31:0]     raw;
        logic [31:0]     bg;
        logic [31:0]     c;
        logic [31:0]     val;
        t_result         r;
        op   = (rq.req_type > REQ_READ) ? REQ_READ : rq.req_type;
        wgt  = (rq.alpha > ALPHA_ONE) ? 9'(ALPHA_ONE) : rq.alpha;
        nb   = pix_bits / 8;
        addr = (64'(rq.pos_x) + pan_x) * nb + (64'(rq.pos_y) + pan_y) * line_pitch;
        lim  = (frame_used < FRAME_BYTES) ? 64'(frame_used) : 64'(FRAME_BYTES);
        r    = '0;
        if (rq.pos_x >= vis_w || rq.pos_y >= vis_h) begin
            r.status = ST_CLIPPED;
        end else if (op == REQ_BLEND && wgt == 0) begin
            r.status = ST_ALPHA_ZERO;
        end else if (pix_bits != BPP32 && pix_bits != BPP16) begin
            r.status = ST_DEPTH;
        end else if (addr + nb > lim) begin
            r.status = ST_BEYOND;
        end else begin
            raw = '0;
            for (int unsigned i = 0; i < nb; i++) begin
                raw[8*i +: 8] = frame_image[addr + i];
            end
            if (op == REQ_READ) begin
                val = raw;
            end else begin
                c = rq.color;
                if (op == REQ_BLEND && wgt != ALPHA_ONE) begin
                    bg = (nb == 2) ? {8'h00, raw[15:11], 3'b000, raw[10:5], 2'b00,
                                      raw[4:0], 3'b000} : raw;
                    c  = {8'h00, mix_channel(c[23:16], bg[23:16], wgt),
                          mix_channel(c[15:8], bg[15:8], wgt),
                          mix_channel(c[7:0], bg[7:0], wgt)};
                end
                val = (nb == 2) ? {16'h0000, c[23:19], c[15:10], c[7:3]} : c;
                for (int unsigned i = 0; i < nb; i++) begin
                    frame_image[addr + i] = val[8*i +: 8];
                end
            end
            r.status       = ST_DONE;
            r.byte_address = addr[20:0];
            r.pixel_value  = val;
        end
        return r;
    endfunction

    function automatic t_request random_request();
        t_request    rq;
        int unsigned span_x;
        int unsigned span_y;
        int unsigned pick;
        span_x = (vis_w == 0) ? 0 : (vis_w > 4096) ? 4095 : vis_w - 1;
        span_y = (vis_h == 0) ? 0 : (vis_h > 4096) ? 4095 : vis_h - 1;
        pick = $urandom_range(99);
        rq.pos_x = 12'((pick < 70) ? $urandom_range(span_x < 7 ? span_x : 7) :
                       (pick < 85) ? $urandom_range(span_x) : $urandom_range(4095));
        pick = $urandom_range(99);
        rq.pos_y = 12'((pick < 70) ? $urandom_range(span_y < 7 ? span_y : 7) :
                       (pick < 85) ? $urandom_range(span_y) : $urandom_range(4095));
        pick = $urandom_range(99);
        rq.req_type = (pick < 35) ? REQ_SET : (pick < 70) ? REQ_BLEND :
                      (pick < 95) ? REQ_READ : REQ_SPARE;
        pick = $urandom_range(99);
        rq.alpha = 9'((pick < 10) ? 0 : (pick < 20) ? ALPHA_ONE :
                      (pick < 25) ? $urandom_range(511, 257) :
                      (pick < 30) ? $urandom_range(511) : $urandom_range(255, 1));
        rq.color = $urandom;
        return rq;
    endfunction

    // Input beats are launched at the falling edge; a held request stays until taken.
    always @(negedge i_clk) begin
        if (!(start && !took)) begin
            if (i_rst_n && job_fifo.size() != 0 && $urandom_range(99) >= idle_pct) begin
                cur_job = job_fifo.pop_front();
                start   = 1'b1;
                i_req   = cur_job.rq;
            end else begin
                start = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        bit      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_res_valid) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: status %0d addr %0h value %0h",
                           o_res.status, o_res.byte_address, o_res.pixel_value);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_res.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_res.status);
                        mismatches++;
                    end
                    if (o_res.byte_address !== want.byte_address) begin
                        $error("byte_address: expected %0h, got %0h",
                               want.byte_address, o_res.byte_address);
                        mismatches++;
                    end
                    if (o_res.pixel_value !== want.pixel_value) begin
                        $error("pixel_value: expected %0h, got %0h",
                               want.pixel_value, o_res.pixel_value);
                        mismatches++;
                    end
                end
            end
            took = start && !busy;
            if (took) begin
                moved = 1'b1;
                want  = predict_pixel(cur_job.rq);
                pending_results.push_back(cur_job.typed ? cur_job.exp : want);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (job_fifo.size() != 0 || start || pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_VIS_W:      vis_w      = val[12:0];
            CFG_VIS_H:      vis_h      = val[12:0];
            CFG_PAN_X:      pan_x      = val[11:0];
            CFG_PAN_Y:      pan_y      = val[11:0];
            CFG_PIX_BITS:   pix_bits   = val[5:0];
            CFG_PITCH:      line_pitch = val[14:0];
            CFG_FRAME_USED: frame_used = val[21:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int unsigned w, h, px, py, bits, pitch, used,
                             input int unsigned idle, count);
        t_pixel_job job;
        wait_drained();
        write_reg(CFG_VIS_W, CFG_DATA_W'(w));
        write_reg(CFG_VIS_H, CFG_DATA_W'(h));
        write_reg(CFG_PAN_X, CFG_DATA_W'(px));
        write_reg(CFG_PAN_Y, CFG_DATA_W'(py));
        write_reg(CFG_PIX_BITS, CFG_DATA_W'(bits));
        write_reg(CFG_PITCH, CFG_DATA_W'(pitch));
        write_reg(CFG_FRAME_USED, CFG_DATA_W'(used));
        idle_pct = idle;
        job.typed = 1'b0;
        job.exp   = '0;
        for (int unsigned k = 0; k < count; k++) begin
            if (k == count / 2) begin
                wait_drained();
            end
            job.rq = random_request();
            job_fifo.push_back(job);
        end
        wait_drained();
    endtask

    initial begin
        t_pixel_job  job;
        int unsigned w;
        int unsigned h;
        int unsigned px;
        int unsigned py;
        int unsigned bits;
        int unsigned pitch;
        int unsigned used;
        int unsigned depth_pick [0:5];
        int unsigned idle_pick [0:3];
        depth_pick = '{BPP16, BPP32, BPP32, BPP16, 8, 24};
        idle_pick  = '{IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT, IDLE_HEAVY};
        idle_pct   = IDLE_NONE;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].bits != pix_bits || directed_plan[i].used != frame_used) begin
                wait_drained();
                if (directed_plan[i].bits != pix_bits) begin
                    write_reg(CFG_PIX_BITS, CFG_DATA_W'(directed_plan[i].bits));
                end
                if (directed_plan[i].used != frame_used) begin
                    write_reg(CFG_FRAME_USED, CFG_DATA_W'(directed_plan[i].used));
                end
            end
            job.rq.req_type      = directed_plan[i].op;
            job.rq.pos_x         = 12'(directed_plan[i].x);
            job.rq.pos_y         = 12'(directed_plan[i].y);
            job.rq.color         = directed_plan[i].color;
            job.rq.alpha         = 9'(directed_plan[i].alpha);
            job.typed            = directed_plan[i].typed;
            job.exp.status       = directed_plan[i].status;
            job.exp.byte_address = 21'(directed_plan[i].addr);
            job.exp.pixel_value  = directed_plan[i].value;
            job_fifo.push_back(job);
        end

        run_phase(640, 480, 0, 0, BPP32, 2560, 1228800, IDLE_NONE, 120);
        run_phase(16, 16, 3, 2, BPP16, 64, 4096, IDLE_HEAVY, 120);
        run_phase(8191, 8191, 0, 0, BPP32, 32767, 4194303, IDLE_LIGHT, 80);
        run_phase(4096, 4096, 4095, 4095, BPP32, 16384, 2097152, IDLE_NONE, 40);
        run_phase(1, 1, 0, 0, BPP32, 0, 4, IDLE_HEAVY, 40);
        run_phase(8, 8, 4095, 0, BPP16, 0, 2097152, IDLE_LIGHT, 100);
        for (int p = 0; p < 4; p++) begin
            w     = $urandom_range(48, 1);
            h     = $urandom_range(48, 1);
            px    = $urandom_range(15);
            py    = $urandom_range(15);
            bits  = depth_pick[$urandom_range(5)];
            pitch = $urandom_range((w + px) * 4 + 16);
            used  = $urandom_range((h + py) * pitch + (w + px) * 4 + 64);
            run_phase(w, h, px, py, bits, pitch, used, idle_pick[p], 90);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== pixel_write_blend_engine_top.f =====
design/pwbe_pkg.sv
design/pwbe_front.sv
design/pwbe_queue.sv
design/pwbe_back.sv
design/pixel_write_blend_engine_top.sv
dv/pixel_write_blend_engine_top_tb.sv
